[hdl/sfd_pkg.sv]
package sfd_pkg;

    localparam logic [7:0]  SYNC_FIRST  = 8'hAA;
    localparam logic [7:0]  SYNC_SECOND = 8'h55;
    localparam logic [15:0] CRC_INIT    = 16'hFFFF;
    localparam logic [15:0] CRC_POLY    = 16'h1021;

    // byte positions inside a frame
    localparam logic [3:0] POS_HUNT    = 4'd0;
    localparam logic [3:0] POS_SYNC2   = 4'd1;
    localparam logic [3:0] POS_CRC_END = 4'd14;  // first byte not covered by the CRC
    localparam logic [3:0] POS_LAST    = 4'd15;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_HDR   = 2'd1;
    localparam logic [1:0] ST_CRC   = 2'd2;
    localparam logic [1:0] ST_RANGE = 2'd3;

    localparam logic [2:0] CFG_VERSION  = 3'd0;
    localparam logic [2:0] CFG_MSG_ID   = 3'd1;
    localparam logic [2:0] CFG_OFF_LIM  = 3'd2;
    localparam logic [2:0] CFG_ANG_LIM  = 3'd3;
    localparam logic [2:0] CFG_CONF_LIM = 3'd4;

    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = 1;

    typedef struct packed {
        logic [7:0]  version;
        logic [7:0]  msg_id;
        logic [7:0]  seq;
        logic [7:0]  flags;
        logic [15:0] offset;
        logic [15:0] angle;
        logic [15:0] conf;
        logic [15:0] width;
        logic [15:0] rx_crc;
        logic [15:0] calc_crc;
    } frame_t;

    typedef struct packed {
        logic [7:0]  expected_version;
        logic [7:0]  expected_message_id;
        logic [14:0] offset_limit;
        logic [14:0] angle_limit;
        logic [15:0] confidence_limit;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  seq;
        logic [7:0]  flags;
        logic [15:0] offset;
        logic [15:0] angle;
        logic [15:0] conf;
        logic [15:0] width;
        logic [31:0] crc_fail_total;
        logic [31:0] format_fail_total;
    } result_t;

    // CRC-16-CCITT, MSB first, one byte
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++)
        begin
            if (c[15])
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

[hdl/sfd_front.sv]
module sfd_front
    import sfd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] rx_byte,
    output logic       push,
    output frame_t     rec
);

    logic [3:0]  pos_reg, pos_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  fb_reg [2:14];

    always_comb
    begin
        pos_next = pos_reg;
        crc_next = crc_reg;
        if (accept)
        begin
            case (pos_reg)
                POS_HUNT:
                begin
                    if (rx_byte == SYNC_FIRST)
                    begin
                        crc_next = crc16_byte(CRC_INIT, rx_byte);
                        pos_next = POS_SYNC2;
                    end
                end
                POS_SYNC2:
                begin
                    if (rx_byte == SYNC_SECOND)
                    begin
                        crc_next = crc16_byte(crc_reg, rx_byte);
                        pos_next = pos_reg + 4'd1;
                    end
                    else if (rx_byte == SYNC_FIRST)
                        crc_next = crc16_byte(CRC_INIT, rx_byte);
                    else
                        pos_next = POS_HUNT;
                end
                default:
                begin
                    if (pos_reg < POS_CRC_END)
                        crc_next = crc16_byte(crc_reg, rx_byte);
                    if (pos_reg == POS_LAST)
                        pos_next = POS_HUNT;
                    else
                        pos_next = pos_reg + 4'd1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= POS_HUNT;
            crc_reg <= CRC_INIT;
        end
        else
        begin
            pos_reg <= pos_next;
            crc_reg <= crc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && pos_reg >= 4'd2 && pos_reg <= POS_CRC_END)
            fb_reg[pos_reg] <= rx_byte;
    end

    assign push = accept && (pos_reg == POS_LAST);

    always_comb
    begin
        rec.version  = fb_reg[2];
        rec.msg_id   = fb_reg[3];
        rec.seq      = fb_reg[4];
        rec.flags    = fb_reg[5];
        rec.offset   = {fb_reg[7], fb_reg[6]};
        rec.angle    = {fb_reg[9], fb_reg[8]};
        rec.conf     = {fb_reg[11], fb_reg[10]};
        rec.width    = {fb_reg[13], fb_reg[12]};
        rec.rx_crc   = {rx_byte, fb_reg[14]};
        rec.calc_crc = crc_reg;
    end

endmodule

[hdl/sfd_queue.sv]
module sfd_queue
    import sfd_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  frame_t wr_data,
    input  logic   pop,
    output frame_t rd_data,
    output logic   full,
    output logic   empty
);

    frame_t            mem [Q_DEPTH];
    logic [Q_AW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [Q_AW:0]     count_reg;

    assign full    = (count_reg == (Q_AW+1)'(Q_DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

[hdl/sfd_back.sv]
module sfd_back
    import sfd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  frame_t  rec,
    input  logic    rec_avail,
    output logic    pop,
    output logic    res_valid,
    input  logic    res_ready,
    output result_t res
);

    logic        valid_reg;
    result_t     res_reg;
    logic [31:0] crc_cnt_reg, crc_cnt_next;
    logic [31:0] fmt_cnt_reg, fmt_cnt_next;
    logic [1:0]  status;
    logic        hdr_bad, crc_bad, range_bad;
    logic signed [16:0] off_s, ang_s, off_lim, ang_lim;

    assign pop = rec_avail && (!valid_reg || res_ready);

    always_comb
    begin
        off_s   = {rec.offset[15], rec.offset};
        ang_s   = {rec.angle[15], rec.angle};
        off_lim = {2'b00, cfg.offset_limit};
        ang_lim = {2'b00, cfg.angle_limit};

        hdr_bad   = (rec.version != cfg.expected_version) ||
                    (rec.msg_id != cfg.expected_message_id);
        crc_bad   = (rec.rx_crc != rec.calc_crc);
        range_bad = (off_s > off_lim) || (off_s < -off_lim) ||
                    (ang_s > ang_lim) || (ang_s < -ang_lim) ||
                    (rec.conf > cfg.confidence_limit);

        crc_cnt_next = crc_cnt_reg;
        fmt_cnt_next = fmt_cnt_reg;
        if (hdr_bad)
        begin
            status       = ST_HDR;
            fmt_cnt_next = fmt_cnt_reg + 32'd1;
        end
        else if (crc_bad)
        begin
            status       = ST_CRC;
            crc_cnt_next = crc_cnt_reg + 32'd1;
        end
        else if (range_bad)
        begin
            status       = ST_RANGE;
            fmt_cnt_next = fmt_cnt_reg + 32'd1;
        end
        else
            status = ST_OK;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= 1'b0;
            crc_cnt_reg <= '0;
            fmt_cnt_reg <= '0;
        end
        else
        begin
            if (pop)
            begin
                valid_reg   <= 1'b1;
                crc_cnt_reg <= crc_cnt_next;
                fmt_cnt_reg <= fmt_cnt_next;
            end
            else if (res_ready)
                valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            res_reg.status            <= status;
            res_reg.seq               <= rec.seq;
            res_reg.flags             <= rec.flags;
            res_reg.offset            <= rec.offset;
            res_reg.angle             <= rec.angle;
            res_reg.conf              <= rec.conf;
            res_reg.width             <= rec.width;
            res_reg.crc_fail_total    <= crc_cnt_next;
            res_reg.format_fail_total <= fmt_cnt_next;
        end
    end

    assign res_valid = valid_reg;
    assign res       = res_reg;

endmodule

[hdl/sync_frame_deframer_crc16.sv]
// Byte-stream deframer: sync 0xAA 0x55, 16-byte frame, CRC-16-CCITT check.
// Throughput: one byte per cycle; s_tready falls only when two finished
// frames are queued behind a stalled output.
// Result path: the byte-15 transfer writes the frame into the queue, then the check registers the result.
// Reset (async, active low) clears the hunt position, CRC, error counters,
// queue and output valid, and loads the register defaults.
module sync_frame_deframer_crc16
    import sfd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] rx_byte
    output logic         m_tvalid,
    input  logic         m_tready,
    // [1:0] status, [9:2] sequence_res, [17:10] flag_bits, [33:18] lateral_offset,
    // [49:34] angle_centideg, [65:50] confidence, [81:66] width_value,
    // [113:82] crc_fail_total, [145:114] format_fail_total, [151:146] zero
    output logic [151:0] m_tdata,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_addr,
    input  logic [15:0]  cfg_wdata
);

    cfg_t    cfg_reg;
    frame_t  f_rec, q_rec;
    result_t res;
    logic    s_accept, q_push, q_pop, q_full, q_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.expected_version    <= 8'd1;
            cfg_reg.expected_message_id <= 8'd1;
            cfg_reg.offset_limit        <= 15'd1000;
            cfg_reg.angle_limit         <= 15'd9000;
            cfg_reg.confidence_limit    <= 16'd1000;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                CFG_VERSION:  cfg_reg.expected_version    <= cfg_wdata[7:0];
                CFG_MSG_ID:   cfg_reg.expected_message_id <= cfg_wdata[7:0];
                CFG_OFF_LIM:  cfg_reg.offset_limit        <= cfg_wdata[14:0];
                CFG_ANG_LIM:  cfg_reg.angle_limit         <= cfg_wdata[14:0];
                CFG_CONF_LIM: cfg_reg.confidence_limit    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign s_tready = !q_full;
    assign s_accept = s_tvalid && s_tready;

    sfd_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (s_accept),
        .rx_byte (s_tdata),
        .push    (q_push),
        .rec     (f_rec)
    );

    sfd_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .wr_data (f_rec),
        .pop     (q_pop),
        .rd_data (q_rec),
        .full    (q_full),
        .empty   (q_empty)
    );

    sfd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .rec       (q_rec),
        .rec_avail (!q_empty),
        .pop       (q_pop),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res       (res)
    );

    assign m_tdata = {6'd0, res.format_fail_total, res.crc_fail_total, res.width, res.conf,
                      res.angle, res.offset, res.flags, res.seq, res.status};

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_push && q_full))
        else $error("frame queue overflow");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("frame queue underflow");

    a_push_on_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> s_tvalid && s_tready)
        else $error("frame pushed without input transfer");

endmodule
